FILE: hdl/dts_pkg.sv
// shared types, character codes, token kinds and keyword tables of the token scanner
package dts_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int LENGTH_BITS_DEF = 16;

    typedef logic [4:0] kind_t;
    typedef logic [7:0] char_t;

    // scanner modes, one-hot
    typedef enum logic [7:0] {
        MODE_IDLE   = 8'b0000_0001,
        MODE_IDENT  = 8'b0000_0010,
        MODE_COLON  = 8'b0000_0100,
        MODE_HASH   = 8'b0000_1000,
        MODE_LINE   = 8'b0001_0000,
        MODE_BLOCK  = 8'b0010_0000,
        MODE_STRING = 8'b0100_0000,
        MODE_SQUOTE = 8'b1000_0000
    } mode_t;

    // token kinds
    localparam kind_t K_COMMA     = 5'd0;
    localparam kind_t K_PERIOD    = 5'd1;
    localparam kind_t K_QMARK     = 5'd2;
    localparam kind_t K_LPAREN    = 5'd3;
    localparam kind_t K_RPAREN    = 5'd4;
    localparam kind_t K_COLON     = 5'd5;
    localparam kind_t K_COLONDASH = 5'd6;
    localparam kind_t K_MUL       = 5'd7;
    localparam kind_t K_ADD       = 5'd8;
    localparam kind_t K_SCHEMES   = 5'd9;
    localparam kind_t K_FACTS     = 5'd10;
    localparam kind_t K_RULES     = 5'd11;
    localparam kind_t K_QUERIES   = 5'd12;
    localparam kind_t K_ID        = 5'd13;
    localparam kind_t K_STRING    = 5'd14;
    localparam kind_t K_COMMENT   = 5'd15;
    localparam kind_t K_UNDEF     = 5'd16;
    localparam kind_t K_EOF       = 5'd17;

    // character codes
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_HASH   = 8'h23;
    localparam char_t CH_QUOTE  = 8'h27;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_DASH   = 8'h2D;
    localparam char_t CH_PERIOD = 8'h2E;
    localparam char_t CH_COLON  = 8'h3A;
    localparam char_t CH_QMARK  = 8'h3F;
    localparam char_t CH_BAR    = 8'h7C;

    // keywords: Schemes, Facts, Rules, Queries
    localparam int KW_COUNT = 4;
    localparam char_t KW_TEXT [KW_COUNT][7] = '{
        '{"S", "c", "h", "e", "m", "e", "s"},
        '{"F", "a", "c", "t", "s", 8'h00, 8'h00},
        '{"R", "u", "l", "e", "s", 8'h00, 8'h00},
        '{"Q", "u", "e", "r", "i", "e", "s"}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd7, 3'd5, 3'd5, 3'd7};
    localparam kind_t KW_KIND [KW_COUNT] = '{K_SCHEMES, K_FACTS, K_RULES, K_QUERIES};

    function automatic logic is_alpha(input char_t c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input char_t c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_nl(input char_t c);
        return c == CH_LF || c == CH_CR;
    endfunction

endpackage

FILE: hdl/datalog_token_scanner_top.sv
// token scanner for a datalog-style language, one source byte per transfer
//
// Each input transfer carries one source byte (or an end-of-input mark). The
// scanner echoes every byte that belongs to a token as it arrives
// (is_record = 0), and once a token is complete it sends a record
// (is_record = 1) with the token kind, its start line and its length. The
// consumer drops the echoed bytes of a token whose record says comment. At
// end of input any open token is closed (unterminated strings and block
// comments come out as undefined), an eof record follows, and the scanner
// returns to its reset state. Both CR and LF count as a line break; line
// numbers and lengths saturate at all ones. The whole scan step for one byte
// is one level of logic from the input ports into a three-entry result
// buffer, so a byte is taken every cycle as long as it makes at most one
// result and out_stall stays low. A byte that makes two or three results
// (a token closed by the next punctuation, end of input) holds in_stall
// while the buffer drains at one result per cycle, out_stall permitting.
// The last result of each byte carries last = 1.
module datalog_token_scanner_top
    import dts_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             char_code,
    input  logic                   end_of_input,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   is_record,
    output logic [7:0]             value_byte,
    output logic [4:0]             token_kind,
    output logic [LINE_BITS-1:0]   token_line,
    output logic [LENGTH_BITS-1:0] token_length,
    output logic                   last
);

    // one result item as held in the buffer
    typedef struct packed {
        logic                   is_record;
        logic [7:0]             value_byte;
        kind_t                  token_kind;
        logic [LINE_BITS-1:0]   token_line;
        logic [LENGTH_BITS-1:0] token_length;
        logic                   last;
    } res_t;

    localparam int RES_DEPTH = 3;

    function automatic res_t make_echo(input char_t ch);
        res_t r;
        r            = '0;
        r.value_byte = ch;
        return r;
    endfunction

    function automatic res_t make_rec(input kind_t kind, input logic [LINE_BITS-1:0] ln,
                                      input logic [LENGTH_BITS-1:0] len);
        res_t r;
        r              = '0;
        r.is_record    = 1'b1;
        r.token_kind   = kind;
        r.token_line   = ln;
        r.token_length = len;
        return r;
    endfunction

    // saturating add of two line counts
    function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] a,
                                                      input logic [LINE_BITS-1:0] b);
        logic [LINE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LINE_BITS] ? '1 : s[LINE_BITS-1:0];
    endfunction

    function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] len);
        return (&len) ? len : len + LENGTH_BITS'(1);
    endfunction

    // ------------------------------------------------------------------
    // scanner state
    // ------------------------------------------------------------------
    mode_t                  mode_reg,  mode_next;
    logic [LINE_BITS-1:0]   line_reg,  line_next;   // current line
    logic [LINE_BITS-1:0]   start_reg, start_next;  // line where the open token began
    logic [LENGTH_BITS-1:0] len_reg,   len_next;    // characters in the open token
    logic [KW_COUNT-1:0]    kw_reg,    kw_next;     // keywords still matching
    logic [LINE_BITS-1:0]   lin_reg,   lin_next;    // breaks inside string or block
    logic                   pend_reg,  pend_next;   // last block byte was a bar

    // result buffer: up to three results per transfer, drained one a cycle while out_stall is low
    res_t       res_reg [RES_DEPTH];
    res_t       res_next [RES_DEPTH];
    logic [1:0] cnt_reg;   // results still to send
    logic [1:0] idx_reg;   // buffer entry at the head
    logic [1:0] n_next;    // results made by the current byte

    logic in_take;
    logic out_take;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_take  = out_valid && !out_stall;
    // a new byte enters once the buffer empties in this cycle
    assign in_stall  = !(cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_take));
    assign in_take   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // scan step: current mode first, then the closing record, then the eof
    // record at end of input, or else a fresh scan of the byte from idle when
    // it ended the previous token or no token was open
    logic   fin;
    kind_t  fin_kind;
    logic   rescan;
    kind_t  id_kind;
    logic   start_tok;
    mode_t  start_mode;
    logic [KW_COUNT-1:0] kw_first;

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kw_next    = kw_reg;
        lin_next   = lin_reg;
        pend_next  = pend_reg;
        n_next     = 2'd0;
        for (int i = 0; i < RES_DEPTH; i++)
        begin
            res_next[i] = '0;
        end
        fin        = 1'b0;
        fin_kind   = K_COMMENT;
        rescan     = 1'b0;
        start_tok  = 1'b0;
        start_mode = MODE_IDLE;
        kw_first   = '0;

        // kind of the identifier held so far; first keyword wins
        id_kind = K_ID;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (kw_reg[k] && len_reg == LENGTH_BITS'(KW_LEN[k]))
            begin
                id_kind = KW_KIND[k];
            end
        end

        if (end_of_input)
        begin
            unique case (mode_reg)
                MODE_IDENT:              begin fin = 1'b1; fin_kind = id_kind;   end
                MODE_COLON:              begin fin = 1'b1; fin_kind = K_COLON;   end
                MODE_HASH, MODE_LINE:    begin fin = 1'b1; fin_kind = K_COMMENT; end
                MODE_BLOCK, MODE_STRING: begin fin = 1'b1; fin_kind = K_UNDEF;   end
                MODE_SQUOTE:             begin fin = 1'b1; fin_kind = K_STRING;  end
                MODE_IDLE:               ;
                default:                 ;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha(char_code) || is_digit(char_code))
                    begin
                        res_next[n_next] = make_echo(char_code);
                        n_next           = n_next + 2'd1;
                        for (int k = 0; k < KW_COUNT; k++)
                        begin
                            if (!(len_reg < LENGTH_BITS'(KW_LEN[k]) &&
                                  KW_TEXT[k][len_reg[2:0]] == char_code))
                            begin
                                kw_next[k] = 1'b0;
                            end
                        end
                        len_next = grow(len_reg);
                    end
                    else
                    begin
                        fin      = 1'b1;
                        fin_kind = id_kind;
                        rescan   = 1'b1;
                    end
                end
                MODE_COLON:
                begin
                    if (char_code == CH_DASH)
                    begin
                        res_next[n_next] = make_echo(char_code);
                        n_next           = n_next + 2'd1;
                        len_next         = grow(len_reg);
                        fin              = 1'b1;
                        fin_kind         = K_COLONDASH;
                    end
                    else
                    begin
                        fin      = 1'b1;
                        fin_kind = K_COLON;
                        rescan   = 1'b1;
                    end
                end
                MODE_HASH:
                begin
                    if (char_code == CH_BAR)
                    begin
                        res_next[n_next] = make_echo(char_code);
                        n_next           = n_next + 2'd1;
                        len_next         = grow(len_reg);
                        pend_next        = 1'b0;
                        mode_next        = MODE_BLOCK;
                    end
                    else if (is_nl(char_code))
                    begin
                        // a comment that starts right at a newline ends there
                        fin      = 1'b1;
                        fin_kind = K_COMMENT;
                        rescan   = 1'b1;
                    end
                    else
                    begin
                        res_next[n_next] = make_echo(char_code);
                        n_next           = n_next + 2'd1;
                        len_next         = grow(len_reg);
                        mode_next        = MODE_LINE;
                    end
                end
                MODE_LINE:
                begin
                    if (is_nl(char_code))
                    begin
                        fin      = 1'b1;
                        fin_kind = K_COMMENT;
                        rescan   = 1'b1;
                    end
                    else
                    begin
                        res_next[n_next] = make_echo(char_code);
                        n_next           = n_next + 2'd1;
                        len_next         = grow(len_reg);
                    end
                end
                MODE_BLOCK:
                begin
                    res_next[n_next] = make_echo(char_code);
                    n_next           = n_next + 2'd1;
                    len_next         = grow(len_reg);
                    if (char_code == CH_HASH && pend_reg)
                    begin
                        fin      = 1'b1;
                        fin_kind = K_COMMENT;
                    end
                    else
                    begin
                        if (is_nl(char_code))
                        begin
                            lin_next = sat_line(lin_reg, LINE_BITS'(1));
                        end
                        pend_next = (char_code == CH_BAR);
                    end
                end
                MODE_STRING:
                begin
                    res_next[n_next] = make_echo(char_code);
                    n_next           = n_next + 2'd1;
                    len_next         = grow(len_reg);
                    if (char_code == CH_QUOTE)
                    begin
                        mode_next = MODE_SQUOTE;
                    end
                    else if (is_nl(char_code))
                    begin
                        lin_next = sat_line(lin_reg, LINE_BITS'(1));
                    end
                end
                MODE_SQUOTE:
                begin
                    // doubled quote stays inside the string
                    if (char_code == CH_QUOTE)
                    begin
                        res_next[n_next] = make_echo(char_code);
                        n_next           = n_next + 2'd1;
                        len_next         = grow(len_reg);
                        mode_next        = MODE_STRING;
                    end
                    else
                    begin
                        fin      = 1'b1;
                        fin_kind = K_STRING;
                        rescan   = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    rescan    = 1'b1;
                end
            endcase
        end

        // close the open token
        if (fin)
        begin
            res_next[n_next] = make_rec(fin_kind, start_next, len_next);
            n_next           = n_next + 2'd1;
            line_next        = sat_line(line_next, lin_next);
            lin_next         = '0;
            pend_next        = 1'b0;
            kw_next          = '0;
            mode_next        = MODE_IDLE;
        end

        if (end_of_input)
        begin
            res_next[n_next] = make_rec(K_EOF, line_next, '0);
            n_next           = n_next + 2'd1;
            mode_next        = MODE_IDLE;
            line_next        = LINE_BITS'(1);
            start_next       = LINE_BITS'(1);
            len_next         = '0;
            kw_next          = '0;
            lin_next         = '0;
            pend_next        = 1'b0;
        end
        else if (rescan)
        begin
            unique case (char_code)
                CH_COMMA, CH_PERIOD, CH_QMARK, CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS:
                begin
                    res_next[n_next] = make_echo(char_code);
                    n_next           = n_next + 2'd1;
                end
                CH_COLON:
                begin
                    start_tok  = 1'b1;
                    start_mode = MODE_COLON;
                end
                CH_HASH:
                begin
                    start_tok  = 1'b1;
                    start_mode = MODE_HASH;
                end
                CH_QUOTE:
                begin
                    start_tok  = 1'b1;
                    start_mode = MODE_STRING;
                end
                CH_SPACE, CH_TAB:
                    ;
                CH_LF, CH_CR:
                    line_next = sat_line(line_next, LINE_BITS'(1));
                default:
                begin
                    if (is_alpha(char_code))
                    begin
                        start_tok  = 1'b1;
                        start_mode = MODE_IDENT;
                        for (int k = 0; k < KW_COUNT; k++)
                        begin
                            kw_first[k] = (KW_TEXT[k][0] == char_code);
                        end
                    end
                    else
                    begin
                        // stray byte: one-character undefined token
                        res_next[n_next] = make_echo(char_code);
                        n_next           = n_next + 2'd1;
                        res_next[n_next] = make_rec(K_UNDEF, line_next, LENGTH_BITS'(1));
                        n_next           = n_next + 2'd1;
                    end
                end
            endcase

            // single-character punctuation records
            unique case (char_code)
                CH_COMMA:  res_next[n_next] = make_rec(K_COMMA,  line_next, LENGTH_BITS'(1));
                CH_PERIOD: res_next[n_next] = make_rec(K_PERIOD, line_next, LENGTH_BITS'(1));
                CH_QMARK:  res_next[n_next] = make_rec(K_QMARK,  line_next, LENGTH_BITS'(1));
                CH_LPAREN: res_next[n_next] = make_rec(K_LPAREN, line_next, LENGTH_BITS'(1));
                CH_RPAREN: res_next[n_next] = make_rec(K_RPAREN, line_next, LENGTH_BITS'(1));
                CH_STAR:   res_next[n_next] = make_rec(K_MUL,    line_next, LENGTH_BITS'(1));
                CH_PLUS:   res_next[n_next] = make_rec(K_ADD,    line_next, LENGTH_BITS'(1));
                default:   ;
            endcase
            if (char_code == CH_COMMA || char_code == CH_PERIOD || char_code == CH_QMARK ||
                char_code == CH_LPAREN || char_code == CH_RPAREN || char_code == CH_STAR ||
                char_code == CH_PLUS)
            begin
                n_next = n_next + 2'd1;
            end

            // open a multi-character token
            if (start_tok)
            begin
                res_next[n_next] = make_echo(char_code);
                n_next           = n_next + 2'd1;
                start_next       = line_next;
                len_next         = LENGTH_BITS'(1);
                lin_next         = '0;
                pend_next        = 1'b0;
                kw_next          = kw_first;
                mode_next        = start_mode;
            end
        end

        // mark the final result of this byte
        for (int i = 0; i < RES_DEPTH; i++)
        begin
            res_next[i].last = (2'(i) + 2'd1 == n_next);
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= LINE_BITS'(1);
            start_reg <= LINE_BITS'(1);
            len_reg   <= '0;
            kw_reg    <= '0;
            lin_reg   <= '0;
            pend_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else if (in_take)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kw_reg    <= kw_next;
            lin_reg   <= lin_next;
            pend_reg  <= pend_next;
            cnt_reg   <= n_next;
            idx_reg   <= 2'd0;
        end
        else if (out_take)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < RES_DEPTH; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    // head of the buffer drives the result ports
    res_t head;
    assign head         = res_reg[idx_reg];
    assign is_record    = head.is_record;
    assign value_byte   = head.value_byte;
    assign token_kind   = head.token_kind;
    assign token_line   = head.token_line;
    assign token_length = head.token_length;
    assign last         = head.last;

`ifndef SYNTHESIS
    // end of input always leaves the reset state and at least the eof record
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && end_of_input |=>
            mode_reg == MODE_IDLE && line_reg == LINE_BITS'(1) && cnt_reg != 2'd0)
    else $error("scanner not back in reset state after end of input");

    // the result flagged last is the final one in the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> cnt_reg == 2'd1)
    else $error("last flag on a result that is not the final one");

    // line numbers start at one and saturate, never wrap to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0 && start_reg != '0)
    else $error("line counter reached zero");
`endif

endmodule

FILE: verif/datalog_token_scanner_tb.sv
// testbench of the token scanner: byte stream stimulus, token prediction and result checks
module tb
    import dts_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LB = 16;                  // line number width
    localparam int NB = 16;                  // token length width
    localparam int RANDOM_ITEMS = 80;        // random bytes after the directed part
    localparam int CYCLE_LIMIT = 100_000;    // watchdog limit

    // one result of the scanner as seen on the output ports
    typedef struct {
        logic          is_record;
        logic [7:0]    value_byte;
        logic [4:0]    token_kind;
        logic [LB-1:0] token_line;
        logic [NB-1:0] token_length;
        logic          last;
    } scan_result_t;

    // scoreboard: tracks the scanner state and the token output still due
    class token_scoreboard;
        mode_t         mode;
        logic [LB-1:0] line_no;
        logic [LB-1:0] tok_line;
        logic [NB-1:0] tok_len;
        logic [3:0]    kw_live;
        logic [LB-1:0] inner_lines;
        bit            bar_seen;
        scan_result_t  tokens_due[$];
        scan_result_t  step_out[$];
        int            errors;
        int            shown;

        function new();
            errors = 0;
            shown = 0;
            clear();
        endfunction

        function void clear();
            mode = MODE_IDLE;
            line_no = LB'(1);
            tok_line = LB'(1);
            tok_len = '0;
            kw_live = '0;
            inner_lines = '0;
            bar_seen = 0;
        endfunction

        function string kw_word(int k);
            case (k)
                0: return "Schemes";
                1: return "Facts";
                2: return "Rules";
                default: return "Queries";
            endcase
        endfunction

        function kind_t kw_token(int k);
            case (k)
                0: return K_SCHEMES;
                1: return K_FACTS;
                2: return K_RULES;
                default: return K_QUERIES;
            endcase
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_break(logic [7:0] c);
            return c == CH_LF || c == CH_CR;
        endfunction

        function logic [LB-1:0] add_line(logic [LB-1:0] a, logic [LB-1:0] b);
            logic [LB:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[LB] ? {LB{1'b1}} : s[LB-1:0];
        endfunction

        function void put(bit rec, logic [7:0] c, kind_t k, logic [LB-1:0] ln,
                          logic [NB-1:0] len);
            scan_result_t r;
            if (step_out.size() >= 3)
                return;
            r.is_record = rec;
            r.value_byte = c;
            r.token_kind = k;
            r.token_line = ln;
            r.token_length = len;
            r.last = 1'b0;
            step_out.push_back(r);
        endfunction

        function void echo(logic [7:0] c);
            put(1'b0, c, '0, '0, '0);
        endfunction

        function void lengthen();
            if (tok_len != {NB{1'b1}})
                tok_len++;
        endfunction

        function void close_token(kind_t k);
            put(1'b1, '0, k, tok_line, tok_len);
            line_no = add_line(line_no, inner_lines);
            inner_lines = '0;
            bar_seen = 0;
            kw_live = '0;
            mode = MODE_IDLE;
        endfunction

        function void open_token(logic [7:0] c, mode_t m);
            echo(c);
            tok_line = line_no;
            tok_len = NB'(1);
            inner_lines = '0;
            bar_seen = 0;
            kw_live = '0;
            mode = m;
        endfunction

        function void single(logic [7:0] c, kind_t k);
            echo(c);
            put(1'b1, '0, k, line_no, NB'(1));
        endfunction

        function kind_t word_kind();
            string w;
            for (int k = 0; k < 4; k++)
            begin
                w = kw_word(k);
                if (kw_live[k] && tok_len == w.len())
                    return kw_token(k);
            end
            return K_ID;
        endfunction

        // a byte seen between tokens
        function void scan_between(logic [7:0] c);
            string w;
            case (c)
                CH_COMMA:  single(c, K_COMMA);
                CH_PERIOD: single(c, K_PERIOD);
                CH_QMARK:  single(c, K_QMARK);
                CH_LPAREN: single(c, K_LPAREN);
                CH_RPAREN: single(c, K_RPAREN);
                CH_STAR:   single(c, K_MUL);
                CH_PLUS:   single(c, K_ADD);
                CH_COLON:  open_token(c, MODE_COLON);
                CH_SPACE, CH_TAB: ;
                CH_LF, CH_CR: line_no = add_line(line_no, LB'(1));
                CH_HASH:   open_token(c, MODE_HASH);
                CH_QUOTE:  open_token(c, MODE_STRING);
                default:
                begin
                    if (is_letter(c))
                    begin
                        open_token(c, MODE_IDENT);
                        for (int k = 0; k < 4; k++)
                        begin
                            w = kw_word(k);
                            if (w[0] == c)
                                kw_live[k] = 1'b1;
                        end
                    end
                    else
                        single(c, K_UNDEF);
                end
            endcase
        endfunction

        // one accepted input transfer: work out its results
        function void predict_tokens(logic [7:0] c, logic eoi);
            string w;
            step_out.delete();
            if (eoi)
            begin
                case (mode)
                    MODE_IDENT:             close_token(word_kind());
                    MODE_COLON:             close_token(K_COLON);
                    MODE_HASH, MODE_LINE:   close_token(K_COMMENT);
                    MODE_BLOCK, MODE_STRING: close_token(K_UNDEF);
                    MODE_SQUOTE:            close_token(K_STRING);
                    default: ;
                endcase
                put(1'b1, '0, K_EOF, line_no, '0);
                clear();
            end
            else
            begin
                case (mode)
                    MODE_IDENT:
                    begin
                        if (is_letter(c) || (c >= "0" && c <= "9"))
                        begin
                            echo(c);
                            for (int k = 0; k < 4; k++)
                            begin
                                w = kw_word(k);
                                if (tok_len < w.len())
                                begin
                                    if (w[int'(tok_len)] != c)
                                        kw_live[k] = 1'b0;
                                end
                                else
                                    kw_live[k] = 1'b0;
                            end
                            lengthen();
                        end
                        else
                        begin
                            close_token(word_kind());
                            scan_between(c);
                        end
                    end
                    MODE_COLON:
                    begin
                        if (c == CH_DASH)
                        begin
                            echo(c);
                            lengthen();
                            close_token(K_COLONDASH);
                        end
                        else
                        begin
                            close_token(K_COLON);
                            scan_between(c);
                        end
                    end
                    MODE_HASH:
                    begin
                        if (c == CH_BAR)
                        begin
                            echo(c);
                            lengthen();
                            bar_seen = 0;
                            mode = MODE_BLOCK;
                        end
                        else if (is_break(c))
                        begin
                            close_token(K_COMMENT);
                            scan_between(c);
                        end
                        else
                        begin
                            echo(c);
                            lengthen();
                            mode = MODE_LINE;
                        end
                    end
                    MODE_LINE:
                    begin
                        if (is_break(c))
                        begin
                            close_token(K_COMMENT);
                            scan_between(c);
                        end
                        else
                        begin
                            echo(c);
                            lengthen();
                        end
                    end
                    MODE_BLOCK:
                    begin
                        echo(c);
                        lengthen();
                        if (c == CH_HASH && bar_seen)
                            close_token(K_COMMENT);
                        else
                        begin
                            if (is_break(c))
                                inner_lines = add_line(inner_lines, LB'(1));
                            bar_seen = (c == CH_BAR);
                        end
                    end
                    MODE_STRING:
                    begin
                        echo(c);
                        lengthen();
                        if (c == CH_QUOTE)
                            mode = MODE_SQUOTE;
                        else if (is_break(c))
                            inner_lines = add_line(inner_lines, LB'(1));
                    end
                    MODE_SQUOTE:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            echo(c);
                            lengthen();
                            mode = MODE_STRING;
                        end
                        else
                        begin
                            close_token(K_STRING);
                            scan_between(c);
                        end
                    end
                    default:
                    begin
                        mode = MODE_IDLE;
                        scan_between(c);
                    end
                endcase
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                tokens_due.push_back(step_out[i]);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (shown < 40)
                $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            shown++;
        endfunction

        // one accepted output transfer against the oldest expected result
        function void check_token_out(scan_result_t got);
            scan_result_t want;
            if (tokens_due.size() == 0)
            begin
                report("unexpected result, value_byte", '0, 32'(got.value_byte));
                return;
            end
            want = tokens_due.pop_front();
            if (got.is_record !== want.is_record)
                report("is_record", 32'(want.is_record), 32'(got.is_record));
            if (got.value_byte !== want.value_byte)
                report("value_byte", 32'(want.value_byte), 32'(got.value_byte));
            if (got.token_kind !== want.token_kind)
                report("token_kind", 32'(want.token_kind), 32'(got.token_kind));
            if (got.token_line !== want.token_line)
                report("token_line", 32'(want.token_line), 32'(got.token_line));
            if (got.token_length !== want.token_length)
                report("token_length", 32'(want.token_length), 32'(got.token_length));
            if (got.last !== want.last)
                report("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic          clk;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [7:0]    char_code = '0;
    logic          end_of_input = 1'b0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          is_record;
    logic [7:0]    value_byte;
    logic [4:0]    token_kind;
    logic [LB-1:0] token_line;
    logic [NB-1:0] token_length;
    logic          last;

    token_scoreboard sb = new();
    int items_sent = 0;
    int cycles = 0;

    datalog_token_scanner_top #(.LINE_BITS(LB), .LENGTH_BITS(NB)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_record    (is_record),
        .value_byte   (value_byte),
        .token_kind   (token_kind),
        .token_line   (token_line),
        .token_length (token_length),
        .last         (last)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // reset held low from the start, released once
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog on the total cycle count
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("datalog_token_scanner_top test failed");
        $finish;
    end

    // idle cycles before a transfer: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 96)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // result side back-pressure: runs of free flow, short stalls, rare long ones
    initial
    begin
        int r;
        int n;
        wait (rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 20);
            end
            else if (r < 92)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                n = $urandom_range(10, 30);
            end
            repeat (n) @(posedge clk);
        end
    end

    // result monitor: every accepted output transfer goes to the scoreboard
    always @(posedge clk)
    begin
        scan_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.is_record = is_record;
            got.value_byte = value_byte;
            got.token_kind = token_kind;
            got.token_line = token_line;
            got.token_length = token_length;
            got.last = last;
            sb.check_token_out(got);
        end
    end

    // one input transfer; valid stays high into the next item when there is no gap
    task automatic send_item(logic [7:0] c, logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.predict_tokens(c, eoi);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // end of source, with a don't-care byte alongside
    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z")) :
                                      8'($urandom_range("a", "z"));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(0, 3) == 0 ? 8'($urandom_range("0", "9")) : rand_letter();
    endfunction

    function automatic logic [7:0] rand_break();
        return $urandom_range(0, 1) ? CH_LF : CH_CR;
    endfunction

    function automatic logic [7:0] rand_not(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == a || c == b);
        return c;
    endfunction

    // one random token, mostly well formed, some noise and cut-off tokens
    task automatic random_token();
        logic [7:0] txt[$];
        string      w;
        string      punct;
        int         n;
        int         r;
        bit         cut;
        punct = ",.?()*+";
        cut = 0;
        case ($urandom_range(0, 19))
            0, 1: txt.push_back(punct[$urandom_range(0, 6)]);
            2:
            begin
                txt.push_back(CH_COLON);
                if ($urandom_range(0, 1))
                    txt.push_back(CH_DASH);
            end
            3, 4:
            begin
                // keyword, sometimes cut short or running on into an identifier
                case ($urandom_range(0, 3))
                    0: w = "Schemes";
                    1: w = "Facts";
                    2: w = "Rules";
                    default: w = "Queries";
                endcase
                r = $urandom_range(0, 3);
                n = (r == 0) ? $urandom_range(1, w.len() - 1) : w.len();
                for (int i = 0; i < n; i++)
                    txt.push_back(w[i]);
                if (r == 1)
                    txt.push_back(rand_alnum());
            end
            5, 6:
            begin
                txt.push_back(rand_letter());
                n = $urandom_range(0, 8);
                repeat (n) txt.push_back(rand_alnum());
            end
            7, 8:
            begin
                // string with escaped quotes and line breaks inside
                txt.push_back(CH_QUOTE);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                    begin
                        txt.push_back(CH_QUOTE);
                        txt.push_back(CH_QUOTE);
                    end
                    else if (r == 1)
                        txt.push_back(rand_break());
                    else if (r < 6)
                        txt.push_back(rand_letter());
                    else
                        txt.push_back(rand_not(CH_QUOTE, CH_QUOTE));
                end
                txt.push_back(CH_QUOTE);
            end
            9:
            begin
                // line comment ended by a line break
                txt.push_back(CH_HASH);
                n = $urandom_range(1, 7);
                txt.push_back(CH_SPACE);
                repeat (n - 1) txt.push_back(rand_not(CH_LF, CH_CR));
                txt.push_back(rand_break());
            end
            10, 11:
            begin
                // block comment; bars, hashes and breaks inside
                txt.push_back(CH_HASH);
                txt.push_back(CH_BAR);
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    r = $urandom_range(0, 5);
                    if (r == 0)
                        txt.push_back(CH_BAR);
                    else if (r == 1)
                        txt.push_back(CH_HASH);
                    else if (r == 2)
                        txt.push_back(rand_break());
                    else
                        txt.push_back(8'($urandom_range(0, 255)));
                end
                txt.push_back(CH_BAR);
                txt.push_back(CH_HASH);
            end
            12:
            begin
                // comment right at a newline
                txt.push_back(CH_HASH);
                txt.push_back(rand_break());
            end
            13, 14:
            begin
                r = $urandom_range(0, 3);
                txt.push_back(r == 0 ? CH_SPACE : r == 1 ? CH_TAB : r == 2 ? CH_LF : CH_CR);
            end
            15: txt.push_back(8'($urandom_range(0, 255)));
            16:
            begin
                // unterminated string or block comment, then end of source
                if ($urandom_range(0, 1))
                    txt.push_back(CH_QUOTE);
                else
                begin
                    txt.push_back(CH_HASH);
                    txt.push_back(CH_BAR);
                end
                n = $urandom_range(0, 3);
                repeat (n) txt.push_back(rand_letter());
                cut = 1;
            end
            17: cut = 1;
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n) txt.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        foreach (txt[i])
            send_item(txt[i], 1'b0);
        if (cut)
            send_end();
        else if ($urandom_range(0, 2) == 0)
            send_item($urandom_range(0, 1) ? CH_SPACE : CH_LF, 1'b0);
    endtask

    // main sequence
    initial
    begin
        int start_count;
        int wait_cycles;
        wait (rst_n);
        @(posedge clk);

        // directed: all punctuation, colon-dash, a colon ended by a letter,
        // comment at newline, the opening bar that cannot close, a keyword
        // ended by a period, a high stray byte, then an escaped quote left
        // open until the end of source
        send_text(",.?()*+:-:x#");
        send_item(CH_LF, 1'b0);
        send_text("#|#|#Facts.");
        send_item(8'hFF, 1'b0);
        send_text("'''");
        send_end();

        // random token stream
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
            random_token();
        send_end();

        // drop valid right at the last accepted transfer
        in_valid <= 1'b0;

        // drain, then wait on to catch stray results
        while (sb.tokens_due.size() > 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 20)
        begin
            @(posedge clk);
            wait_cycles++;
        end

        if (sb.errors == 0)
            $display("datalog_token_scanner_top test passed");
        else
            $display("datalog_token_scanner_top test failed");
        $finish;
    end

endmodule
